>>> rtl/core/spq_pkg.sv
// Shared types and codes for the sorted process queue.
package spq_pkg;

   localparam int SPQ_DEPTH_DEFAULT = 16;

   localparam int ID_W    = 8;
   localparam int TIME_W  = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
   } entry_type;

   // What a cell tells its right-hand neighbor about itself.
   typedef struct packed {
      logic occ;
      logic after;
   } stat_type;

   // Command broadcast to every cell in the row.
   typedef struct packed {
      op_type    op;
      logic      by_id;
      entry_type key;
   } bcast_type;

endpackage

>>> rtl/core/spq_cell.sv
// One cell of the sorted row: holds one entry and shifts with its neighbors.
module spq_cell import spq_pkg::*; (
   input  logic      clock,
   input  bcast_type bcast,
   input  logic      occ,
   input  stat_type  left_stat,
   input  entry_type left_entry,
   input  entry_type right_entry,
   input  logic      seen_in,
   input  entry_type found_in,
   output entry_type entry,
   output stat_type  stat,
   output logic      seen_out,
   output entry_type found_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      after;
   logic      match;
   logic      shift_in;
   logic      ins_here;

   // Held entry sorts strictly after the new key: equal keys land behind.
   assign after = occ && ((entry_ff.arrival > bcast.key.arrival) ||
                          ((entry_ff.arrival == bcast.key.arrival) &&
                           (entry_ff.id > bcast.key.id)));

   assign match = (bcast.op == OP_REMOVE) && occ &&
                  (!bcast.by_id || (entry_ff.id == bcast.key.id));

   assign shift_in = left_stat.occ && left_stat.after;
   assign ins_here = (!occ || after) && left_stat.occ && !left_stat.after;

   assign seen_out  = seen_in || match;
   assign found_out = (match && !seen_in) ? entry_ff : found_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (bcast.op)
         OP_INSERT: begin
            if (shift_in) begin
               entry_in = left_entry;
            end else if (ins_here) begin
               entry_in = bcast.key;
            end
         end
         OP_REMOVE: begin
            if (seen_out) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign stat.occ   = occ;
   assign stat.after = after;

endmodule

>>> rtl/core/sorted_process_queue_unit.sv
// Top level of the sorted process queue: a row of shifting cells plus a result register.
// A command's response beat is registered: it becomes valid in the cycle after the command beat is taken.
// Throughput: one command per cycle while the response side keeps taking beats; every cell compares
//   against the new key at once, and the first-match search ripples across the row within that cycle.
// Reset clears the entry count and the response valid; cell contents are not cleared,
//   cells at or above the count are simply treated as empty.
module sorted_process_queue_unit import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [ID_W-1:0]    req_proc_id,
   input  logic [TIME_W-1:0]  req_arrival_time,
   input  logic [TIME_W-1:0]  req_burst_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [ID_W-1:0]    rsp_out_id,
   output logic [TIME_W-1:0]  rsp_out_arrival,
   output logic [TIME_W-1:0]  rsp_out_burst,
   output logic [COUNT_W-1:0] rsp_entry_count
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   // Occupancy count and response register.
   logic [CntW-1:0] count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      status_ff, status_in;
   entry_type       out_ff, out_in;

   logic       accept;
   logic       full;
   logic       empty;
   bcast_type  bcast;
   logic       found;
   status_type status;

   // Row wiring: cell i owns index i; in the chains, index i feeds cell i and i+1 comes out.
   entry_type cell_entry [QUEUE_DEPTH];
   stat_type  cell_stat  [QUEUE_DEPTH];
   logic      cell_occ   [QUEUE_DEPTH];
   logic      seen_chain [QUEUE_DEPTH+1];
   entry_type found_chain[QUEUE_DEPTH+1];

   // Take a new command whenever the response slot is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // Decode the command into the broadcast the cells act on.
   always_comb begin
      bcast.key.id      = req_proc_id;
      bcast.key.arrival = req_arrival_time;
      bcast.key.burst   = req_burst_length;
      bcast.by_id       = 1'b0;
      bcast.op          = OP_NONE;
      if (accept) begin
         unique case (req_cmd)
            CMD_INSERT: begin
               if (!full) bcast.op = OP_INSERT;
            end
            CMD_POP: begin
               // Pop is a remove where every held cell matches: the first wins.
               if (!empty) bcast.op = OP_REMOVE;
            end
            CMD_REMOVE: begin
               bcast.op    = OP_REMOVE;
               bcast.by_id = 1'b1;
            end
            default: begin
               bcast.op = OP_NONE;
            end
         endcase
      end
   end

   assign seen_chain[0]  = 1'b0;
   assign found_chain[0] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      stat_type  left_stat;
      entry_type left_entry;
      entry_type right_entry;

      assign cell_occ[i] = (count_ff > CntW'(i));

      if (i == 0) begin : g_head
         // Head cell: the new key lands here if this cell is empty or sorts after it.
         assign left_stat.occ   = 1'b1;
         assign left_stat.after = 1'b0;
         assign left_entry      = bcast.key;
      end else begin : g_body
         assign left_stat  = cell_stat[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         // Tail cell: whatever shifts in past the count is never read.
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .bcast       (bcast),
         .occ         (cell_occ[i]),
         .left_stat   (left_stat),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .seen_in     (seen_chain[i]),
         .found_in    (found_chain[i]),
         .entry       (cell_entry[i]),
         .stat        (cell_stat[i]),
         .seen_out    (seen_chain[i+1]),
         .found_out   (found_chain[i+1])
      );
   end

   assign found = seen_chain[QUEUE_DEPTH];

   // Status and count for the command in flight.
   always_comb begin
      status   = ST_NOT_FOUND;
      count_in = count_ff;
      priority if (bcast.op == OP_INSERT) begin
         status   = ST_OK;
         count_in = count_ff + CntW'(1);
      end else if (accept && (req_cmd == CMD_INSERT)) begin
         status = ST_FULL;
      end else if (found) begin
         status   = ST_OK;
         count_in = count_ff - CntW'(1);
      end else begin
         status = ST_NOT_FOUND;
      end
   end

   // Load the response on accept, drop valid once the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      out_in       = out_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = status;
         out_in       = found_chain[QUEUE_DEPTH];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   // The count reported is the count after the command, i.e. the register itself.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_id      = out_ff.id;
   assign rsp_out_arrival = out_ff.arrival;
   assign rsp_out_burst   = out_ff.burst;
   assign rsp_entry_count = COUNT_W'(count_ff);

endmodule

>>> verif/sorted_process_queue_unit_tb.sv
// Self-checking testbench for the sorted process queue: predicts every response and checks it.
`timescale 1ns / 1ps

module sorted_process_queue_unit_tb;
   import spq_pkg::*;

   localparam int DEPTH = SPQ_DEPTH_DEFAULT;
   // Command code that the package leaves unassigned; the queue must ignore it.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      status_type          status;
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   arrival;
      logic [TIME_W-1:0]   burst;
      logic [COUNT_W-1:0]  count;
   } queue_result;

   // Shadow copy of the queue plus the responses still owed by the block.
   class queue_scoreboard;
      entry_type   held[$];
      queue_result owed[$];
      int depth;
      int errors, beats;
      int n_insert, n_full, n_pop, n_remove, n_miss, n_unused, peak;

      function new(int d);
         depth = d;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Apply one accepted command to the shadow queue and queue up its response.
      function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] pid,
                                 logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur);
         queue_result r;
         entry_type   e;
         int          pos;
         r.status  = ST_NOT_FOUND;
         r.id      = '0;
         r.arrival = '0;
         r.burst   = '0;
         case (cmd)
            CMD_INSERT: begin
               n_insert++;
               if (held.size() >= depth) begin
                  r.status = ST_FULL;
                  n_full++;
               end else begin
                  // Equal keys land after the entries already held.
                  pos = held.size();
                  foreach (held[i]) begin
                     if (held[i].arrival > arr || (held[i].arrival == arr && held[i].id > pid)) begin
                        pos = i;
                        break;
                     end
                  end
                  e.id      = pid;
                  e.arrival = arr;
                  e.burst   = bur;
                  held.insert(pos, e);
                  r.status = ST_OK;
               end
            end
            CMD_POP: begin
               n_pop++;
               if (held.size() > 0) begin
                  e = held.pop_front();
                  r.status  = ST_OK;
                  r.id      = e.id;
                  r.arrival = e.arrival;
                  r.burst   = e.burst;
               end else begin
                  n_miss++;
               end
            end
            CMD_REMOVE: begin
               n_remove++;
               pos = -1;
               foreach (held[i]) begin
                  if (held[i].id == pid) begin
                     pos = i;
                     break;
                  end
               end
               if (pos >= 0) begin
                  e = held[pos];
                  held.delete(pos);
                  r.status  = ST_OK;
                  r.id      = e.id;
                  r.arrival = e.arrival;
                  r.burst   = e.burst;
               end else begin
                  n_miss++;
               end
            end
            default: n_unused++;
         endcase
         if (held.size() > peak) peak = held.size();
         r.count = COUNT_W'(held.size());
         owed.push_back(r);
      endfunction

      // Compare one response beat against the oldest owed response.
      function void check_response(logic [STAT_W-1:0] st, logic [ID_W-1:0] pid,
                                   logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur,
                                   logic [COUNT_W-1:0] cnt);
         queue_result r;
         beats++;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] unexpected response beat: status=%0d id=%0d count=%0d",
                        $realtime, st, pid, cnt);
            return;
         end
         r = owed.pop_front();
         if (st !== r.status || pid !== r.id || arr !== r.arrival || bur !== r.burst ||
             cnt !== r.count) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("[%0t] mismatch on response %0d", $realtime, beats);
               $display("   expected status=%0d id=%0d arrival=%0d burst=%0d count=%0d",
                        r.status, r.id, r.arrival, r.burst, r.count);
               $display("   actual   status=%0d id=%0d arrival=%0d burst=%0d count=%0d",
                        st, pid, arr, bur, cnt);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = CMD_POP;
   logic [ID_W-1:0]     req_proc_id = '0;
   logic [TIME_W-1:0]   req_arrival_time = '0;
   logic [TIME_W-1:0]   req_burst_length = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [ID_W-1:0]     rsp_out_id;
   logic [TIME_W-1:0]   rsp_out_arrival;
   logic [TIME_W-1:0]   rsp_out_burst;
   logic [COUNT_W-1:0]  rsp_entry_count;

   queue_scoreboard sb;

   // Sender idles only when this is set; cleared for stretches of back-to-back beats.
   bit send_idle = 1'b1;
   int commands_sent = 0;

   sorted_process_queue_unit #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_proc_id      (req_proc_id),
      .req_arrival_time (req_arrival_time),
      .req_burst_length (req_burst_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_arrival  (rsp_out_arrival),
      .rsp_out_burst    (rsp_out_burst),
      .rsp_entry_count  (rsp_entry_count)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Present one command beat after a random gap, hold it until taken, then note it.
   // Called at a rising edge; returns at the edge where the beat was accepted.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] pid,
                               input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bur);
      int gap;
      gap = send_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_proc_id      <= pid;
      req_arrival_time <= arr;
      req_burst_length <= bur;
      do @(posedge clock); while (!req_ready);
      sb.note_command(cmd, pid, arr, bur);
      if (cmd != CMD_UNUSED) commands_sent++;
   endtask

   // Drop valid and hold off until every owed response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Draw one random command; the phase weights steer toward filling or draining.
   task automatic send_random(input int insert_pct, input int pop_pct);
      int          roll;
      logic [ID_W-1:0]   pid;
      logic [TIME_W-1:0] arr;
      roll = $urandom_range(0, 99);
      // Duplicate ids and equal arrival times come from narrow ranges.
      pid = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
      case ($urandom_range(0, 9))
         0:       arr = '0;
         1:       arr = '1;
         2, 3, 4: arr = TIME_W'($urandom_range(0, 15));
         default: arr = TIME_W'($urandom);
      endcase
      if (roll < 4) begin
         send_command(CMD_UNUSED, pid, arr, TIME_W'($urandom));
      end else if (roll < 4 + insert_pct) begin
         send_command(CMD_INSERT, pid, arr, TIME_W'($urandom));
      end else if (roll < 4 + insert_pct + pop_pct) begin
         send_command(CMD_POP, pid, arr, TIME_W'($urandom));
      end else begin
         // Mostly aim removes at an id that is actually held.
         if (sb.held.size() > 0 && $urandom_range(0, 9) < 7)
            pid = sb.held[$urandom_range(0, sb.held.size() - 1)].id;
         send_command(CMD_REMOVE, pid, arr, TIME_W'($urandom));
      end
   endtask

   // Response side: stall a random number of cycles per beat, with quiet stretches.
   initial begin : rsp_side
      int stall, beat_no;
      bit quiet;
      beat_no = 0;
      quiet   = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (beat_no % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
         stall = quiet ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beat_no++;
      end
   end

   // Check every response beat taken at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_out_id, rsp_out_arrival, rsp_out_burst,
                           rsp_entry_count);
   end

   initial begin : stimulus
      int phase_len, insert_pct, pop_pct, held_off;
      sb = new(DEPTH);
      held_off = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue corner cases and the unused code.
      send_command(CMD_POP, 8'd0, 16'd0, 16'd0);
      send_command(CMD_REMOVE, 8'd0, 16'd0, 16'd0);
      send_command(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
      // Field extremes, then equal keys and a same-time smaller id.
      send_command(CMD_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_command(CMD_INSERT, 8'h00, 16'h0000, 16'h0000);
      send_command(CMD_INSERT, 8'h5A, 16'd100, 16'd1);
      send_command(CMD_INSERT, 8'h5A, 16'd100, 16'd2);
      send_command(CMD_INSERT, 8'h10, 16'd100, 16'd3);
      // Duplicate ids: the first in queue order must go.
      send_command(CMD_REMOVE, 8'h5A, 16'd0, 16'd0);
      send_command(CMD_REMOVE, 8'h77, 16'd0, 16'd0);
      send_command(CMD_POP, 8'd0, 16'd0, 16'd0);
      // Fill to the brim, then try one more.
      while (sb.held.size() < DEPTH)
         send_command(CMD_INSERT, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
      send_command(CMD_INSERT, 8'hA5, 16'd7, 16'd7);
      send_command(CMD_REMOVE, 8'hFF, 16'd0, 16'd0);
      send_command(CMD_POP, 8'd0, 16'd0, 16'd0);
      drain_responses();

      // Random: alternate fill-heavy, drain-heavy and mixed phases.
      while (commands_sent < 370) begin
         phase_len = $urandom_range(10, 40);
         case ($urandom_range(0, 2))
            0:       begin insert_pct = 76; pop_pct = 10; end
            1:       begin insert_pct = 15; pop_pct = 46; end
            default: begin insert_pct = 40; pop_pct = 28; end
         endcase
         send_idle = ($urandom_range(0, 3) != 0);
         repeat (phase_len) send_random(insert_pct, pop_pct);
         if (!held_off && commands_sent > 200) begin
            drain_responses();
            held_off = 1;
         end
      end

      // Wind down: wait for the last responses, then keep watching for stray beats.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.pending() != 0) sb.errors++;

      $display("Ran %0d commands: %0d inserts (%0d refused as full), %0d pops, %0d removes",
               sb.n_insert + sb.n_pop + sb.n_remove + sb.n_unused, sb.n_insert, sb.n_full,
               sb.n_pop, sb.n_remove);
      $display("%0d pops/removes found nothing, %0d unused codes, peak occupancy %0d, %0d errors",
               sb.n_miss, sb.n_unused, sb.peak, sb.errors);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_process_queue_unit.sv
verif/sorted_process_queue_unit_tb.sv
